FILE: hw/rtl/spi_nor_flash_command_sequencer_core_assert.svh
// Assertion macros used by the sequencer output buffer.
// Each macro expects clk in scope; SNFC_ASSERT also expects rst_n.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property outside reset
`define SNFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included
`define SNFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SNFC_ASSERT(lbl, prop, msg)
`define SNFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/snfc_pkg.sv
package snfc_pkg;

  // Field widths
  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 25;
  localparam int BYTE_W  = 8;
  localparam int FUNC_W  = 3;
  localparam int POLL_W  = 24;
  localparam int CFG_W   = 24;

  // Page size (power of two, 16 to 4096)
  localparam int PAGE_BYTES = 256;
  localparam int PAGE_W     = $clog2(PAGE_BYTES);
  localparam int CHUNK_W    = PAGE_W + 1;

  // Results per transfer
  localparam int MAX_RES = 3;
  localparam int RCNT_W  = 2;

  // Request codes
  localparam logic [FUNC_W-1:0] F_INIT  = 3'd0;
  localparam logic [FUNC_W-1:0] F_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] F_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] F_ERASE = 3'd3;
  localparam logic [FUNC_W-1:0] F_HBYTE = 3'd4;
  localparam logic [FUNC_W-1:0] F_REPLY = 3'd5;

  // Config register indexes
  localparam logic CFG_POLL_LIMIT  = 1'b0;
  localparam logic CFG_EXPECTED_ID = 1'b1;
  localparam logic [CFG_W-1:0] POLL_LIMIT_RST  = 24'hFFFFFF;
  localparam logic [CFG_W-1:0] EXPECTED_ID_RST = 24'hEF4020;

  // Flash opcodes
  localparam logic [7:0] OP_RST_EN  = 8'h66;
  localparam logic [7:0] OP_RST_MEM = 8'h99;
  localparam logic [7:0] OP_JEDEC   = 8'h9F;
  localparam logic [7:0] OP_READ    = 8'h03;
  localparam logic [7:0] OP_WREN    = 8'h06;
  localparam logic [7:0] OP_RDSR    = 8'h05;
  localparam logic [7:0] OP_PROG    = 8'h02;
  localparam logic [7:0] OP_ERASE   = 8'hD8;

  // Status register bits
  localparam int SR_WIP_BIT = 0;
  localparam int SR_WEL_BIT = 1;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_ID      = 4'd1,
    M_READ    = 4'd2,
    M_WR_WEL  = 4'd3,
    M_WR_DATA = 4'd4,
    M_WR_POLL = 4'd5,
    M_ER_WEL  = 4'd6,
    M_ER_POLL = 4'd7
  } mode_t;

  typedef enum logic [1:0] {
    K_CMD     = 2'd0,
    K_TOFLASH = 2'd1,
    K_TOHOST  = 2'd2,
    K_STATUS  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         opcode;
    logic               has_address;
    logic [ADDR_W-1:0]  flash_address;
    logic [LEN_W-1:0]   byte_count;
    logic [BYTE_W-1:0]  out_byte;
    logic               ok;
  } res_t;

  typedef struct packed {
    mode_t               mode;
    logic [ADDR_W-1:0]   cur_addr;
    logic [LEN_W-1:0]    bytes_left;
    logic [CHUNK_W-1:0]  chunk_left;
    logic [POLL_W-1:0]   polls_left;
    logic [1:0]          id_index;
    logic                id_match;
  } seq_st_t;

  localparam res_t RES_NONE = '{kind: K_CMD, opcode: '0, has_address: 1'b0,
                                flash_address: '0, byte_count: '0,
                                out_byte: '0, ok: 1'b0};

  function automatic res_t mk_cmd(logic [7:0] op, logic has_a,
                                  logic [ADDR_W-1:0] a, logic [LEN_W-1:0] cnt);
    res_t r;
    r = RES_NONE;
    r.kind          = K_CMD;
    r.opcode        = op;
    r.has_address   = has_a;
    r.flash_address = a;
    r.byte_count    = cnt;
    return r;
  endfunction

  function automatic res_t mk_data(kind_t k, logic [BYTE_W-1:0] b);
    res_t r;
    r = RES_NONE;
    r.kind     = k;
    r.out_byte = b;
    return r;
  endfunction

  function automatic res_t mk_status(logic okv);
    res_t r;
    r = RES_NONE;
    r.kind = K_STATUS;
    r.ok   = okv;
    return r;
  endfunction

endpackage

FILE: hw/rtl/snfc_step.sv
module snfc_step (
  input  snfc_pkg::seq_st_t                st,
  input  logic [snfc_pkg::FUNC_W-1:0]      func,
  input  logic [snfc_pkg::ADDR_W-1:0]      address,
  input  logic [snfc_pkg::LEN_W-1:0]       length,
  input  logic [snfc_pkg::BYTE_W-1:0]      data_byte,
  input  logic [snfc_pkg::CFG_W-1:0]       poll_limit,
  input  logic [snfc_pkg::CFG_W-1:0]       expected_id,
  output snfc_pkg::seq_st_t                st_nxt,
  output snfc_pkg::res_t                   res [snfc_pkg::MAX_RES],
  output logic [snfc_pkg::RCNT_W-1:0]      res_cnt
);

  logic                             is_req;
  logic [snfc_pkg::ADDR_W-1:0]      cur_inc;
  logic [snfc_pkg::LEN_W-1:0]       bl_dec;
  logic [snfc_pkg::CHUNK_W-1:0]     cl_dec;
  logic [snfc_pkg::POLL_W-1:0]      pl_dec;
  logic [snfc_pkg::POLL_W-1:0]      polls_init;
  logic [snfc_pkg::CHUNK_W-1:0]     chunk_raw;
  logic [snfc_pkg::CHUNK_W-1:0]     chunk;
  logic [1:0]                       id_inc;
  logic [7:0]                       id_exp;
  logic                             id_eq;
  logic                             wip;
  logic                             wel;

  // Shared arithmetic for the current step
  assign is_req  = (func == snfc_pkg::F_INIT) || (func == snfc_pkg::F_READ) ||
                   (func == snfc_pkg::F_WRITE) || (func == snfc_pkg::F_ERASE);
  assign cur_inc = st.cur_addr + snfc_pkg::ADDR_W'(1);
  assign bl_dec  = st.bytes_left - snfc_pkg::LEN_W'(1);
  assign cl_dec  = st.chunk_left - snfc_pkg::CHUNK_W'(1);
  assign pl_dec  = st.polls_left - snfc_pkg::POLL_W'(1);
  assign polls_init = (poll_limit == '0) ? snfc_pkg::POLL_W'(1) : poll_limit;
  assign wip = data_byte[snfc_pkg::SR_WIP_BIT];
  assign wel = data_byte[snfc_pkg::SR_WEL_BIT];

  // Bytes up to the next page boundary, clipped to what is left
  assign chunk_raw = snfc_pkg::CHUNK_W'(snfc_pkg::PAGE_BYTES) -
                     {1'b0, st.cur_addr[snfc_pkg::PAGE_W-1:0]};
  assign chunk = ({{(snfc_pkg::LEN_W-snfc_pkg::CHUNK_W){1'b0}}, chunk_raw} > st.bytes_left)
               ? st.bytes_left[snfc_pkg::CHUNK_W-1:0] : chunk_raw;

  // Pick the expected ID byte for this reply
  always_comb begin
    case (st.id_index)
      2'd0:    id_exp = expected_id[23:16];
      2'd1:    id_exp = expected_id[15:8];
      default: id_exp = expected_id[7:0];
    endcase
  end
  assign id_eq  = (id_exp == data_byte);
  assign id_inc = st.id_index + 2'd1;

  // Next state
  always_comb begin
    st_nxt = st;
    if (is_req && st.mode == snfc_pkg::M_IDLE) begin
      if (func == snfc_pkg::F_INIT) begin
        st_nxt.id_index = 2'd0;
        st_nxt.id_match = 1'b1;
        st_nxt.mode     = snfc_pkg::M_ID;
      end else if (func == snfc_pkg::F_ERASE) begin
        st_nxt.cur_addr = address;
        st_nxt.mode     = snfc_pkg::M_ER_WEL;
      end else if (length != '0) begin
        st_nxt.cur_addr   = address;
        st_nxt.bytes_left = length;
        st_nxt.mode = (func == snfc_pkg::F_READ) ? snfc_pkg::M_READ : snfc_pkg::M_WR_WEL;
      end
    end else if (func == snfc_pkg::F_HBYTE && st.mode == snfc_pkg::M_WR_DATA) begin
      st_nxt.cur_addr   = cur_inc;
      st_nxt.bytes_left = bl_dec;
      st_nxt.chunk_left = cl_dec;
      if (cl_dec == '0) begin
        st_nxt.polls_left = polls_init;
        st_nxt.mode       = snfc_pkg::M_WR_POLL;
      end
    end else if (func == snfc_pkg::F_REPLY) begin
      unique case (st.mode)
        snfc_pkg::M_ID: begin
          if (!id_eq) st_nxt.id_match = 1'b0;
          if (id_inc == 2'd3) begin
            st_nxt.id_index = 2'd0;
            st_nxt.mode     = snfc_pkg::M_IDLE;
          end else begin
            st_nxt.id_index = id_inc;
          end
        end
        snfc_pkg::M_READ: begin
          st_nxt.cur_addr   = cur_inc;
          st_nxt.bytes_left = bl_dec;
          if (bl_dec == '0) st_nxt.mode = snfc_pkg::M_IDLE;
        end
        snfc_pkg::M_WR_WEL, snfc_pkg::M_ER_WEL: begin
          if (!wel) begin
            st_nxt.mode = snfc_pkg::M_IDLE;
          end else if (st.mode == snfc_pkg::M_ER_WEL) begin
            st_nxt.polls_left = polls_init;
            st_nxt.mode       = snfc_pkg::M_ER_POLL;
          end else begin
            st_nxt.chunk_left = chunk;
            st_nxt.mode       = snfc_pkg::M_WR_DATA;
          end
        end
        snfc_pkg::M_WR_POLL, snfc_pkg::M_ER_POLL: begin
          if (!wip) begin
            if (st.mode == snfc_pkg::M_ER_POLL || st.bytes_left == '0) begin
              st_nxt.mode = snfc_pkg::M_IDLE;
            end else begin
              st_nxt.mode = snfc_pkg::M_WR_WEL;
            end
          end else begin
            st_nxt.polls_left = pl_dec;
            if (pl_dec == '0) st_nxt.mode = snfc_pkg::M_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Results
  always_comb begin
    res[0]  = snfc_pkg::RES_NONE;
    res[1]  = snfc_pkg::RES_NONE;
    res[2]  = snfc_pkg::RES_NONE;
    res_cnt = 2'd0;
    if (is_req && st.mode == snfc_pkg::M_IDLE) begin
      if (func == snfc_pkg::F_INIT) begin
        res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RST_EN, 1'b0, '0, '0);
        res[1]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RST_MEM, 1'b0, '0, '0);
        res[2]  = snfc_pkg::mk_cmd(snfc_pkg::OP_JEDEC, 1'b0, '0, snfc_pkg::LEN_W'(3));
        res_cnt = 2'd3;
      end else if (func == snfc_pkg::F_ERASE || (func == snfc_pkg::F_WRITE && length != '0))
      begin
        res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_WREN, 1'b0, '0, '0);
        res[1]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, snfc_pkg::LEN_W'(1));
        res_cnt = 2'd2;
      end else if (length == '0) begin
        res[0]  = snfc_pkg::mk_status(1'b1);
        res_cnt = 2'd1;
      end else begin
        res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_READ, 1'b1, address, length);
        res_cnt = 2'd1;
      end
    end else if (func == snfc_pkg::F_HBYTE && st.mode == snfc_pkg::M_WR_DATA) begin
      res[0]  = snfc_pkg::mk_data(snfc_pkg::K_TOFLASH, data_byte);
      res_cnt = 2'd1;
      if (cl_dec == '0) begin
        res[1]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, snfc_pkg::LEN_W'(1));
        res_cnt = 2'd2;
      end
    end else if (func == snfc_pkg::F_REPLY) begin
      unique case (st.mode)
        snfc_pkg::M_ID: begin
          if (id_inc == 2'd3) begin
            res[0]  = snfc_pkg::mk_status(st.id_match & id_eq);
            res_cnt = 2'd1;
          end
        end
        snfc_pkg::M_READ: begin
          res[0]  = snfc_pkg::mk_data(snfc_pkg::K_TOHOST, data_byte);
          res_cnt = 2'd1;
          if (bl_dec == '0) begin
            res[1]  = snfc_pkg::mk_status(1'b1);
            res_cnt = 2'd2;
          end
        end
        snfc_pkg::M_WR_WEL, snfc_pkg::M_ER_WEL: begin
          if (!wel) begin
            res[0]  = snfc_pkg::mk_status(1'b0);
            res_cnt = 2'd1;
          end else if (st.mode == snfc_pkg::M_ER_WEL) begin
            res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_ERASE, 1'b1, st.cur_addr, '0);
            res[1]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, snfc_pkg::LEN_W'(1));
            res_cnt = 2'd2;
          end else begin
            res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_PROG, 1'b1, st.cur_addr,
                        {{(snfc_pkg::LEN_W-snfc_pkg::CHUNK_W){1'b0}}, chunk});
            res_cnt = 2'd1;
          end
        end
        snfc_pkg::M_WR_POLL, snfc_pkg::M_ER_POLL: begin
          if (!wip) begin
            if (st.mode == snfc_pkg::M_ER_POLL || st.bytes_left == '0) begin
              res[0]  = snfc_pkg::mk_status(1'b1);
              res_cnt = 2'd1;
            end else begin
              res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_WREN, 1'b0, '0, '0);
              res[1]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, snfc_pkg::LEN_W'(1));
              res_cnt = 2'd2;
            end
          end else if (pl_dec == '0) begin
            res[0]  = snfc_pkg::mk_status(1'b0);
            res_cnt = 2'd1;
          end else begin
            res[0]  = snfc_pkg::mk_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, snfc_pkg::LEN_W'(1));
            res_cnt = 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/snfc_out_buf.sv
`include "spi_nor_flash_command_sequencer_core_assert.svh"

module snfc_out_buf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  snfc_pkg::res_t                res_in [snfc_pkg::MAX_RES],
  input  logic [snfc_pkg::RCNT_W-1:0]   cnt_in,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output snfc_pkg::res_t                out_res,
  output logic                          out_last
);

  snfc_pkg::res_t               res_r [snfc_pkg::MAX_RES];
  logic [snfc_pkg::RCNT_W-1:0]  cnt_r;
  logic [snfc_pkg::RCNT_W-1:0]  cnt_nxt;
  logic [snfc_pkg::RCNT_W-1:0]  rd_r;
  logic [snfc_pkg::RCNT_W-1:0]  rd_nxt;
  logic                         out_xfer;

  // Serialize the held results, one per transfer
  assign out_valid = (cnt_r != '0);
  assign out_last  = (rd_r == cnt_r - snfc_pkg::RCNT_W'(1));
  assign out_res   = res_r[rd_r];
  assign out_xfer  = out_valid && out_ready;
  assign free      = !out_valid || (out_xfer && out_last);

  // Advance the read pointer or take a new set
  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (load) begin
      cnt_nxt = cnt_in;
      rd_nxt  = '0;
    end else if (out_xfer) begin
      if (out_last) begin
        cnt_nxt = '0;
        rd_nxt  = '0;
      end else begin
        rd_nxt = rd_r + snfc_pkg::RCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r[0] <= res_in[0];
      res_r[1] <= res_in[1];
      res_r[2] <= res_in[2];
    end
  end

  `SNFC_ASSERT(a_rd_in_range, out_valid |-> (rd_r < cnt_r), "read pointer past held results")
  `SNFC_ASSERT(a_load_only_free, (load && out_valid) |-> (out_xfer && out_last),
    "new set loaded over undelivered results")
  `SNFC_ASSERT(a_drain_empties, (out_xfer && out_last && !load) |=> !out_valid,
    "buffer not empty after final transfer")
  `SNFC_ASSERT_ALWAYS(a_cnt_max, !rst_n || (cnt_r <= snfc_pkg::RCNT_W'(snfc_pkg::MAX_RES)),
    "result count beyond three")

endmodule

FILE: hw/rtl/spi_nor_flash_command_sequencer_core.sv
// Channel   Dir  tdata (low bit up)                              tuser        tlast
// in_       in   address[23:0] length[48:24] data_byte[56:49]    func[2:0]    -
// out_      out  opcode[7:0] has_address[8] flash_address[32:9]  kind[1:0]    last
//                byte_count[57:33] out_byte[65:58] ok[66]
// cfg_      in   index 0 poll_limit, index 1 expected_id          -            -
//
// An input transfer updates the registered state and loads its zero to
// three results into the output buffer; the first is offered in the next cycle.
// An item giving k results sends them one result per cycle while out_tready
// is high; in_tready rises again in the cycle the final result transfers.
// Reset (rst_n low, synchronous) returns to idle with empty output and the
// register reset values. Output stalls hold in_tready low once results wait.
module spi_nor_flash_command_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // address, length, data_byte
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // opcode, has_address, flash_address, byte_count, out_byte, ok
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [23:0] cfg_wdata
);

  snfc_pkg::seq_st_t            st_r;
  snfc_pkg::seq_st_t            st_nxt;
  logic [snfc_pkg::CFG_W-1:0]   poll_limit_r;
  logic [snfc_pkg::CFG_W-1:0]   expected_id_r;
  snfc_pkg::res_t               step_res [snfc_pkg::MAX_RES];
  logic [snfc_pkg::RCNT_W-1:0]  step_cnt;
  snfc_pkg::res_t               out_res;
  logic                         buf_free;
  logic                         in_xfer;

  assign in_tready = buf_free;
  assign in_xfer   = in_tvalid && buf_free;

  snfc_step u_step (
    .st          (st_r),
    .func        (in_tuser),
    .address     (in_tdata[23:0]),
    .length      (in_tdata[48:24]),
    .data_byte   (in_tdata[56:49]),
    .poll_limit  (poll_limit_r),
    .expected_id (expected_id_r),
    .st_nxt      (st_nxt),
    .res         (step_res),
    .res_cnt     (step_cnt)
  );

  // Commit the state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= snfc_pkg::M_IDLE;
      st_r.cur_addr   <= '0;
      st_r.bytes_left <= '0;
      st_r.chunk_left <= '0;
      st_r.polls_left <= '0;
      st_r.id_index   <= '0;
      st_r.id_match   <= 1'b1;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r  <= snfc_pkg::POLL_LIMIT_RST;
      expected_id_r <= snfc_pkg::EXPECTED_ID_RST;
    end else if (cfg_we) begin
      if (cfg_idx == snfc_pkg::CFG_POLL_LIMIT) poll_limit_r <= cfg_wdata;
      if (cfg_idx == snfc_pkg::CFG_EXPECTED_ID) expected_id_r <= cfg_wdata;
    end
  end

  snfc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .res_in    (step_res),
    .cnt_in    (step_cnt),
    .free      (buf_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  // Pack the result fields
  assign out_tuser = out_res.kind;
  assign out_tdata = {5'b0, out_res.ok, out_res.out_byte, out_res.byte_count,
                      out_res.flash_address, out_res.has_address, out_res.opcode};

endmodule

FILE: dv/spi_nor_flash_command_sequencer_core_tb.sv
`timescale 1ns / 100ps

module spi_nor_flash_command_sequencer_core_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;

  // One expected result: the payload fields plus the marker of the final one
  typedef struct packed {
    snfc_pkg::res_t r;
    logic last;
  } flash_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [23:0] cfg_wdata = '0;

  // Sequencer state as predicted from the accepted transfers
  snfc_pkg::mode_t                sq_mode = snfc_pkg::M_IDLE;
  logic [snfc_pkg::ADDR_W-1:0]    sq_addr = '0;
  logic [snfc_pkg::LEN_W-1:0]     sq_left = '0;
  logic [snfc_pkg::CHUNK_W-1:0]   sq_chunk = '0;
  logic [snfc_pkg::POLL_W-1:0]    sq_polls = '0;
  logic [1:0]                     sq_id_pos = '0;
  logic                           sq_id_ok = 1'b1;
  logic [snfc_pkg::CFG_W-1:0]     reg_poll_limit = snfc_pkg::POLL_LIMIT_RST;
  logic [snfc_pkg::CFG_W-1:0]     reg_expected_id = snfc_pkg::EXPECTED_ID_RST;

  flash_result_t pending_flash_results[$];
  int unsigned   err_cnt = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   ready_wait = 0;
  bit            tx_idle_en = 1'b1;
  bit            rx_idle_en = 1'b1;
  bit            hold_req = 1'b0;
  bit            hold_ack = 1'b0;

  spi_nor_flash_command_sequencer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic void emit(snfc_pkg::kind_t k, logic [7:0] op, logic ha,
                               logic [snfc_pkg::ADDR_W-1:0] a,
                               logic [snfc_pkg::LEN_W-1:0] cnt, logic [7:0] b, logic okv);
    flash_result_t e;
    e.r.kind          = k;
    e.r.opcode        = op;
    e.r.has_address   = ha;
    e.r.flash_address = a;
    e.r.byte_count    = cnt;
    e.r.out_byte      = b;
    e.r.ok            = okv;
    e.last            = 1'b0;
    pending_flash_results.push_back(e);
  endfunction

  function automatic void emit_cmd(logic [7:0] op, logic ha, logic [snfc_pkg::ADDR_W-1:0] a,
                                   logic [snfc_pkg::LEN_W-1:0] cnt);
    emit(snfc_pkg::K_CMD, op, ha, a, cnt, 8'h00, 1'b0);
  endfunction

  function automatic void close_operation(logic okv);
    emit(snfc_pkg::K_STATUS, 8'h00, 1'b0, '0, '0, 8'h00, okv);
    sq_mode = snfc_pkg::M_IDLE;
  endfunction

  function automatic void issue_write_enable(snfc_pkg::mode_t next);
    emit_cmd(snfc_pkg::OP_WREN, 1'b0, '0, '0);
    emit_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, 25'd1);
    sq_mode = next;
  endfunction

  function automatic void issue_status_poll(snfc_pkg::mode_t next);
    emit_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, 25'd1);
    sq_polls = (reg_poll_limit == '0) ? 24'd1 : reg_poll_limit;
    sq_mode = next;
  endfunction

  // Advance the predicted sequencer by one accepted transfer and queue its results
  function automatic void sequence_flash_item(logic [2:0] fn, logic [snfc_pkg::ADDR_W-1:0] a,
                                              logic [snfc_pkg::LEN_W-1:0] len, logic [7:0] b);
    int n0;
    int room;
    logic [7:0] id_byte;
    flash_result_t tail;
    n0 = pending_flash_results.size();
    if (fn <= snfc_pkg::F_ERASE && sq_mode == snfc_pkg::M_IDLE) begin
      if (fn == snfc_pkg::F_INIT) begin
        emit_cmd(snfc_pkg::OP_RST_EN, 1'b0, '0, '0);
        emit_cmd(snfc_pkg::OP_RST_MEM, 1'b0, '0, '0);
        emit_cmd(snfc_pkg::OP_JEDEC, 1'b0, '0, 25'd3);
        sq_id_pos = '0;
        sq_id_ok = 1'b1;
        sq_mode = snfc_pkg::M_ID;
      end else if (fn == snfc_pkg::F_ERASE) begin
        sq_addr = a;
        issue_write_enable(snfc_pkg::M_ER_WEL);
      end else if (len == '0) begin
        close_operation(1'b1);
      end else if (fn == snfc_pkg::F_READ) begin
        sq_addr = a;
        sq_left = len;
        emit_cmd(snfc_pkg::OP_READ, 1'b1, a, len);
        sq_mode = snfc_pkg::M_READ;
      end else begin
        sq_addr = a;
        sq_left = len;
        issue_write_enable(snfc_pkg::M_WR_WEL);
      end
    end else if (fn == snfc_pkg::F_HBYTE && sq_mode == snfc_pkg::M_WR_DATA) begin
      emit(snfc_pkg::K_TOFLASH, 8'h00, 1'b0, '0, '0, b, 1'b0);
      sq_addr = sq_addr + snfc_pkg::ADDR_W'(1);
      sq_left = sq_left - snfc_pkg::LEN_W'(1);
      sq_chunk = sq_chunk - snfc_pkg::CHUNK_W'(1);
      if (sq_chunk == '0) issue_status_poll(snfc_pkg::M_WR_POLL);
    end else if (fn == snfc_pkg::F_REPLY) begin
      case (sq_mode)
        snfc_pkg::M_ID: begin
          id_byte = 8'(reg_expected_id >> (16 - 8 * int'(sq_id_pos)));
          if (id_byte != b) sq_id_ok = 1'b0;
          sq_id_pos = sq_id_pos + 2'd1;
          if (sq_id_pos == 2'd3) begin
            sq_id_pos = '0;
            close_operation(sq_id_ok);
          end
        end
        snfc_pkg::M_READ: begin
          emit(snfc_pkg::K_TOHOST, 8'h00, 1'b0, '0, '0, b, 1'b0);
          sq_addr = sq_addr + snfc_pkg::ADDR_W'(1);
          sq_left = sq_left - snfc_pkg::LEN_W'(1);
          if (sq_left == '0) close_operation(1'b1);
        end
        snfc_pkg::M_WR_WEL, snfc_pkg::M_ER_WEL: begin
          if (!b[snfc_pkg::SR_WEL_BIT]) begin
            close_operation(1'b0);
          end else if (sq_mode == snfc_pkg::M_ER_WEL) begin
            emit_cmd(snfc_pkg::OP_ERASE, 1'b1, sq_addr, '0);
            issue_status_poll(snfc_pkg::M_ER_POLL);
          end else begin
            // program up to the end of the current page
            room = snfc_pkg::PAGE_BYTES - int'(sq_addr % snfc_pkg::PAGE_BYTES);
            if (room > int'(sq_left)) room = int'(sq_left);
            sq_chunk = snfc_pkg::CHUNK_W'(room);
            emit_cmd(snfc_pkg::OP_PROG, 1'b1, sq_addr, snfc_pkg::LEN_W'(room));
            sq_mode = snfc_pkg::M_WR_DATA;
          end
        end
        snfc_pkg::M_WR_POLL, snfc_pkg::M_ER_POLL: begin
          if (!b[snfc_pkg::SR_WIP_BIT]) begin
            if (sq_mode == snfc_pkg::M_ER_POLL || sq_left == '0) close_operation(1'b1);
            else issue_write_enable(snfc_pkg::M_WR_WEL);
          end else begin
            sq_polls = sq_polls - snfc_pkg::POLL_W'(1);
            if (sq_polls == '0) close_operation(1'b0);
            else emit_cmd(snfc_pkg::OP_RDSR, 1'b0, '0, 25'd1);
          end
        end
        default: ;
      endcase
    end
    // flag the final result of this transfer
    if (pending_flash_results.size() > n0) begin
      tail = pending_flash_results.pop_back();
      tail.last = 1'b1;
      pending_flash_results.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    flash_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_flash_results.size() == 0) begin
        report_mismatch($sformatf("result with none awaited, kind %0d", out_tuser));
      end else begin
        w = pending_flash_results.pop_front();
        if (out_tuser !== w.r.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_tuser, w.r.kind));
        if (out_tdata[7:0] !== w.r.opcode)
          report_mismatch($sformatf("opcode got %0h want %0h", out_tdata[7:0], w.r.opcode));
        if (out_tdata[8] !== w.r.has_address)
          report_mismatch($sformatf("has_address got %0b want %0b", out_tdata[8],
                                    w.r.has_address));
        if (out_tdata[32:9] !== w.r.flash_address)
          report_mismatch($sformatf("flash_address got %0h want %0h", out_tdata[32:9],
                                    w.r.flash_address));
        if (out_tdata[57:33] !== w.r.byte_count)
          report_mismatch($sformatf("byte_count got %0h want %0h", out_tdata[57:33],
                                    w.r.byte_count));
        if (out_tdata[65:58] !== w.r.out_byte)
          report_mismatch($sformatf("out_byte got %0h want %0h", out_tdata[65:58],
                                    w.r.out_byte));
        if (out_tdata[66] !== w.r.ok)
          report_mismatch($sformatf("ok got %0b want %0b", out_tdata[66], w.r.ok));
        if (out_tlast !== w.last)
          report_mismatch($sformatf("last got %0b want %0b", out_tlast, w.last));
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- result side

  // Stall after random transfers; hold off for a long stretch on request
  always @(posedge clk) begin
    int gap;
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      ready_wait <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready && rx_idle_en) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_tready <= 1'b0;
        ready_wait <= gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end else begin
      out_tready <= !rx_idle_en || ($urandom_range(0, 7) != 0);
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_item(logic [2:0] fn, logic [snfc_pkg::ADDR_W-1:0] a = '0,
                           logic [snfc_pkg::LEN_W-1:0] len = '0, logic [7:0] b = '0);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, b, len, a};
    in_tuser <= fn;
    do @(posedge clk); while (!in_tready);
    sequence_flash_item(fn, a, len, b);
  endtask

  task automatic reply(logic [7:0] b);
    send_item(snfc_pkg::F_REPLY, '0, '0, b);
  endtask

  task automatic host_byte(logic [7:0] b);
    send_item(snfc_pkg::F_HBYTE, '0, '0, b);
  endtask

  // Drop valid, wait for every awaited result, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_flash_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [snfc_pkg::CFG_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == snfc_pkg::CFG_POLL_LIMIT) reg_poll_limit = val;
    else reg_expected_id = val;
  endtask

  task automatic send_noise();
    logic [2:0] fn;
    logic [snfc_pkg::LEN_W-1:0] len;
    fn = 3'($urandom_range(0, 7));
    // keep requests that could start from idle short
    if (sq_mode == snfc_pkg::M_IDLE) len = snfc_pkg::LEN_W'($urandom_range(0, 8));
    else len = snfc_pkg::LEN_W'($urandom_range(0, 25'h1000000));
    send_item(fn, snfc_pkg::ADDR_W'($urandom), len, 8'($urandom));
  endtask

  task automatic start_random_request();
    int pick;
    int r;
    logic [snfc_pkg::ADDR_W-1:0] a;
    logic [snfc_pkg::LEN_W-1:0] len;
    pick = $urandom_range(0, 19);
    r = $urandom_range(0, 39);
    a = snfc_pkg::ADDR_W'($urandom);
    if ($urandom_range(0, 1) == 1) a[7:0] = 8'($urandom_range(240, 255));
    if (r == 0) len = '0;
    else if (r < 28) len = snfc_pkg::LEN_W'($urandom_range(1, 8));
    else if (r < 39) len = snfc_pkg::LEN_W'($urandom_range(9, 40));
    else len = snfc_pkg::LEN_W'($urandom_range(200, 300));
    if (pick < 3) send_item(snfc_pkg::F_INIT);
    else if (pick < 7) send_item(snfc_pkg::F_ERASE, a);
    else send_item((pick < 12) ? snfc_pkg::F_READ : snfc_pkg::F_WRITE, a, len);
  endtask

  // Answer whatever the sequencer waits for, with occasional stray transfers
  task automatic drive_flash_traffic(int n_ops);
    int done_ops;
    logic [7:0] b;
    done_ops = 0;
    while (done_ops < n_ops || sq_mode != snfc_pkg::M_IDLE) begin
      if (done_ops < n_ops && $urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        done_ops++;
        b = 8'($urandom);
        case (sq_mode)
          snfc_pkg::M_IDLE: start_random_request();
          snfc_pkg::M_ID: begin
            if ($urandom_range(0, 6) != 0)
              b = 8'(reg_expected_id >> (16 - 8 * int'(sq_id_pos)));
            reply(b);
          end
          snfc_pkg::M_WR_DATA: host_byte(b);
          snfc_pkg::M_WR_WEL, snfc_pkg::M_ER_WEL: begin
            b[snfc_pkg::SR_WEL_BIT] = ($urandom_range(0, 9) != 0);
            reply(b);
          end
          snfc_pkg::M_WR_POLL, snfc_pkg::M_ER_POLL: begin
            b[snfc_pkg::SR_WIP_BIT] = ($urandom_range(0, 4) < 2);
            reply(b);
          end
          default: reply(b);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_requests();
    // init with the reset ID
    send_item(snfc_pkg::F_INIT);
    reply(8'hEF);
    reply(8'h40);
    reply(8'h20);
    // stray transfers while idle
    send_item(3'd6, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
    send_item(3'd7, 24'hFFFFFF, 25'h1000000, 8'hFF);
    host_byte(8'hFF);
    reply(8'hFF);
    // zero-length read and write
    send_item(snfc_pkg::F_READ, 24'h000100, '0);
    send_item(snfc_pkg::F_WRITE, 24'hFFFFFF, '0);
    // read across the top of the address space, with requests ignored while busy
    send_item(snfc_pkg::F_READ, 24'hFFFFFF, 25'd2);
    send_item(snfc_pkg::F_WRITE, 24'h000000, 25'd4);
    host_byte(8'h3C);
    reply(8'h00);
    send_item(snfc_pkg::F_INIT);
    reply(8'hFF);
    // two-byte write split at the page and address wrap
    send_item(snfc_pkg::F_WRITE, 24'hFFFFFF, 25'd2);
    reply(8'h02);
    host_byte(8'hFF);
    reply(8'h01);
    reply(8'h00);
    reply(8'h03);
    host_byte(8'h00);
    reply(8'hFE);
    // erase refused by a clear WEL
    send_item(snfc_pkg::F_ERASE, 24'hABCDEF);
    reply(8'hFD);
    // write of the whole 24-bit address space, refused by a clear WEL
    send_item(snfc_pkg::F_WRITE, 24'h000000, 25'h1000000);
    reply(8'h00);
  endtask

  task automatic test_register_settings();
    // a zero poll limit acts as one
    write_reg(snfc_pkg::CFG_POLL_LIMIT, 24'h000000);
    send_item(snfc_pkg::F_ERASE, 24'h000000);
    reply(8'h02);
    reply(8'hFF);
    // poll limit runs out while programming
    write_reg(snfc_pkg::CFG_POLL_LIMIT, 24'd2);
    send_item(snfc_pkg::F_WRITE, 24'h123456, 25'd1);
    reply(8'h02);
    host_byte(8'hA5);
    reply(8'h01);
    reply(8'h01);
    // largest limit: erase finishes after one busy poll
    write_reg(snfc_pkg::CFG_POLL_LIMIT, 24'hFFFFFF);
    send_item(snfc_pkg::F_ERASE, 24'hFFFFFF);
    reply(8'h02);
    reply(8'h01);
    reply(8'h00);
    // ID extremes: a mismatch on the third byte, then a full match
    write_reg(snfc_pkg::CFG_EXPECTED_ID, 24'h000000);
    send_item(snfc_pkg::F_INIT);
    reply(8'h00);
    reply(8'h00);
    reply(8'h01);
    write_reg(snfc_pkg::CFG_EXPECTED_ID, 24'hFFFFFF);
    send_item(snfc_pkg::F_INIT);
    reply(8'hFF);
    reply(8'hFF);
    reply(8'hFF);
  endtask

  task automatic test_output_backpressure();
    settle();
    tx_idle_en = 1'b0;
    hold_req = ~hold_req;
    send_item(snfc_pkg::F_READ, 24'hFFFFF0, 25'd40);
    repeat (40) reply(8'($urandom));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    write_reg(snfc_pkg::CFG_POLL_LIMIT, snfc_pkg::POLL_LIMIT_RST);
    write_reg(snfc_pkg::CFG_EXPECTED_ID, snfc_pkg::EXPECTED_ID_RST);
    drive_flash_traffic(40);
    // back to back on both sides with the tightest poll limit
    write_reg(snfc_pkg::CFG_POLL_LIMIT, 24'd1);
    write_reg(snfc_pkg::CFG_EXPECTED_ID, 24'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    drive_flash_traffic(40);
    write_reg(snfc_pkg::CFG_POLL_LIMIT, 24'($urandom_range(2, 6)));
    write_reg(snfc_pkg::CFG_EXPECTED_ID, 24'($urandom));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drive_flash_traffic(40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_requests();
    test_register_settings();
    test_output_backpressure();
    test_random_traffic();
    settle();
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: spi_nor_flash_command_sequencer_core.f
+incdir+hw/rtl
hw/rtl/snfc_pkg.sv
hw/rtl/snfc_step.sv
hw/rtl/snfc_out_buf.sv
hw/rtl/spi_nor_flash_command_sequencer_core.sv
dv/spi_nor_flash_command_sequencer_core_tb.sv
